/* rtl/core/onewire_bus_master_macros.svh */
// assertion macros for the 1-wire bus master
// used by rtl/core/onewire_bus_master.sv, no other dependencies
`ifndef ONEWIRE_BUS_MASTER_MACROS_SVH
`define ONEWIRE_BUS_MASTER_MACROS_SVH

// same-cycle implication under reset
`define OWBM_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("onewire_bus_master: check failed");

// next-cycle implication under reset
`define OWBM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("onewire_bus_master: check failed");

`endif

/* rtl/core/owbm_pkg.sv */
// shared types and constants of the 1-wire bus master
// no dependencies
package owbm_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESET   = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_TRIPLET = 3'd4;
    localparam logic [2:0] OP_NONE    = 3'd0;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_BUSY    = 2'd2;

    localparam int TIMER_W = 9;
    typedef logic [TIMER_W-1:0] timer_t;

    localparam int RESET_LOW_TICKS = 480;
    localparam int SLOT_TICKS      = 70;
    localparam int PRESENCE_WAIT   = 70;
    localparam int RESET_RECOVERY  = 410;
    localparam int SHORT_LOW       = 6;
    localparam int ZERO_RELEASE    = 10;
    localparam int READ_WAIT       = 9;

    localparam timer_t T_RESET_LOW  = TIMER_W'(RESET_LOW_TICKS);
    localparam timer_t T_PRESENCE   = TIMER_W'(PRESENCE_WAIT);
    localparam timer_t T_RECOVERY   = TIMER_W'(RESET_RECOVERY);
    localparam timer_t T_SHORT_LOW  = TIMER_W'(SHORT_LOW);
    localparam timer_t T_WR0_LOW    = TIMER_W'(SLOT_TICKS - ZERO_RELEASE);
    localparam timer_t T_WR1_REL    = TIMER_W'(SLOT_TICKS - SHORT_LOW);
    localparam timer_t T_WR0_REL    = TIMER_W'(ZERO_RELEASE);
    localparam timer_t T_READ_WAIT  = TIMER_W'(READ_WAIT);
    localparam timer_t T_READ_REC   = TIMER_W'(SLOT_TICKS - SHORT_LOW - READ_WAIT);

    typedef struct packed {
        logic       drive_low;
        logic       drive_high;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic       present;
        logic [7:0] read_value;
        logic       id_bit;
        logic       complement_bit;
        logic       taken_bit;
    } res_t;

endpackage

/* rtl/core/owbm_if.sv */
// request and result channels of the 1-wire bus master
// no dependencies
interface owbm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] data;
    logic       power;
    logic       search_direction;
    logic       line_level;

    modport source (output valid, output op, output data, output power,
                    output search_direction, output line_level, input ready);
    modport sink   (input valid, input op, input data, input power,
                    input search_direction, input line_level, output ready);
endinterface

interface owbm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       drive_high;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic       present;
    logic [7:0] read_value;
    logic       id_bit;
    logic       complement_bit;
    logic       taken_bit;

    modport source (output valid, output drive_low, output drive_high, output busy_res,
                    output done_res, output status, output present, output read_value,
                    output id_bit, output complement_bit, output taken_bit, input ready);
    modport sink   (input valid, input drive_low, input drive_high, input busy_res,
                    input done_res, input status, input present, input read_value,
                    input id_bit, input complement_bit, input taken_bit, output ready);
endinterface

/* rtl/core/onewire_bus_master.sv */
// 1-wire bus master sequencer: reset/presence, byte write, byte read, search triplet
// depends on owbm_pkg, owbm_if.sv and onewire_bus_master_macros.svh
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------------
//  req     | in  | op, data, power, search_direction, line_level
//  res     | out | drive_low, drive_high, busy_res, done_res, status, present,
//          |     | read_value, id_bit, complement_bit, taken_bit
//
// one request per clock while req.ready is high; each gives one registered result
// the sequencer state and the result register are updated at the same edge
// req.ready drops only while a result is held and res.ready is low
// rst_n clears the sequencer to idle and empties the result register
`include "onewire_bus_master_macros.svh"

module onewire_bus_master (
    input  logic              clk,
    input  logic              rst_n,
    owbm_req_if.sink          req,
    owbm_res_if.source        res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_REL   = 4'd5;
    localparam logic [3:0] PH_RD_LOW   = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_REC   = 4'd8;

    logic [3:0]      phase_reg, phase_next;
    owbm_pkg::timer_t slot_timer_reg, slot_timer_next;
    logic [2:0]      bit_counter_reg, bit_counter_next;
    logic [7:0]      shift_byte_reg, shift_byte_next;
    logic            first_read_reg, first_read_next;
    logic            second_read_reg, second_read_next;
    logic            chosen_direction_reg, chosen_direction_next;
    logic            pullup_request_reg, pullup_request_next;
    logic            pullup_active_reg, pullup_active_next;
    logic            presence_seen_reg, presence_seen_next;
    logic [7:0]      held_read_reg, held_read_next;
    logic [2:0]      run_kind_reg, run_kind_next;

    owbm_pkg::res_t  res_reg, res_next;
    logic            res_valid_reg;

    logic            accept;
    owbm_pkg::timer_t timer_dec;
    logic [7:0]      shifted;
    logic            pick;
    logic            wr_bit;

    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        phase_next            = phase_reg;
        slot_timer_next       = slot_timer_reg;
        bit_counter_next      = bit_counter_reg;
        shift_byte_next       = shift_byte_reg;
        first_read_next       = first_read_reg;
        second_read_next      = second_read_reg;
        chosen_direction_next = chosen_direction_reg;
        pullup_request_next   = pullup_request_reg;
        pullup_active_next    = pullup_active_reg;
        presence_seen_next    = presence_seen_reg;
        held_read_next        = held_read_reg;
        run_kind_next         = run_kind_reg;

        timer_dec = (slot_timer_reg != '0) ? slot_timer_reg - 1'b1 : '0;
        shifted   = {1'b0, shift_byte_reg[7:1]};
        wr_bit    = (run_kind_reg == owbm_pkg::OP_TRIPLET) ? chosen_direction_reg
                                                           : shift_byte_reg[0];
        if (first_read_reg != second_read_reg)
            pick = first_read_reg;
        else
            pick = first_read_reg | shift_byte_reg[0];

        res_next            = '0;
        res_next.drive_low  = (phase_reg == PH_RST_LOW) || (phase_reg == PH_WR_LOW)
                              || (phase_reg == PH_RD_LOW);
        res_next.drive_high = (phase_reg == PH_IDLE) && pullup_active_reg;
        res_next.status     = owbm_pkg::STATUS_OK;

        if (req.op == owbm_pkg::OP_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                slot_timer_next = timer_dec;
                if (timer_dec == '0)
                begin
                    unique case (phase_reg)
                        PH_RST_LOW:
                        begin
                            phase_next      = PH_RST_WAIT;
                            slot_timer_next = owbm_pkg::T_PRESENCE;
                        end
                        PH_RST_WAIT:
                        begin
                            presence_seen_next = !req.line_level;
                            phase_next         = PH_RST_REC;
                            slot_timer_next    = owbm_pkg::T_RECOVERY;
                        end
                        PH_WR_LOW:
                        begin
                            phase_next      = PH_WR_REL;
                            slot_timer_next = wr_bit ? owbm_pkg::T_WR1_REL
                                                     : owbm_pkg::T_WR0_REL;
                        end
                        PH_WR_REL:
                        begin
                            if (run_kind_reg != owbm_pkg::OP_WRITE)
                            begin
                                phase_next        = PH_IDLE;
                                run_kind_next     = owbm_pkg::OP_NONE;
                                res_next.done_res = 1'b1;
                            end
                            else if (bit_counter_reg == 3'd7)
                            begin
                                pullup_active_next = pullup_request_reg;
                                phase_next         = PH_IDLE;
                                run_kind_next      = owbm_pkg::OP_NONE;
                                res_next.done_res  = 1'b1;
                            end
                            else
                            begin
                                bit_counter_next = bit_counter_reg + 1'b1;
                                shift_byte_next  = shifted;
                                phase_next       = PH_WR_LOW;
                                slot_timer_next  = shifted[0] ? owbm_pkg::T_SHORT_LOW
                                                              : owbm_pkg::T_WR0_LOW;
                            end
                        end
                        PH_RD_LOW:
                        begin
                            phase_next      = PH_RD_WAIT;
                            slot_timer_next = owbm_pkg::T_READ_WAIT;
                        end
                        PH_RD_WAIT:
                        begin
                            if (run_kind_reg == owbm_pkg::OP_READ)
                                shift_byte_next = {req.line_level, shift_byte_reg[7:1]};
                            else if (bit_counter_reg == 3'd0)
                                first_read_next = req.line_level;
                            else
                                second_read_next = req.line_level;
                            phase_next      = PH_RD_REC;
                            slot_timer_next = owbm_pkg::T_READ_REC;
                        end
                        PH_RD_REC:
                        begin
                            if (run_kind_reg == owbm_pkg::OP_READ)
                            begin
                                if (bit_counter_reg == 3'd7)
                                begin
                                    held_read_next    = shift_byte_reg;
                                    phase_next        = PH_IDLE;
                                    run_kind_next     = owbm_pkg::OP_NONE;
                                    res_next.done_res = 1'b1;
                                end
                                else
                                begin
                                    bit_counter_next = bit_counter_reg + 1'b1;
                                    phase_next       = PH_RD_LOW;
                                    slot_timer_next  = owbm_pkg::T_SHORT_LOW;
                                end
                            end
                            else if (bit_counter_reg == 3'd0)
                            begin
                                bit_counter_next = 3'd1;
                                phase_next       = PH_RD_LOW;
                                slot_timer_next  = owbm_pkg::T_SHORT_LOW;
                            end
                            else
                            begin
                                chosen_direction_next = pick;
                                if (first_read_reg && second_read_reg)
                                begin
                                    phase_next        = PH_IDLE;
                                    run_kind_next     = owbm_pkg::OP_NONE;
                                    res_next.done_res = 1'b1;
                                end
                                else
                                begin
                                    phase_next      = PH_WR_LOW;
                                    slot_timer_next = pick ? owbm_pkg::T_SHORT_LOW
                                                           : owbm_pkg::T_WR0_LOW;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next        = PH_IDLE;
                            slot_timer_next   = '0;
                            run_kind_next     = owbm_pkg::OP_NONE;
                            res_next.done_res = 1'b1;
                        end
                    endcase
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            res_next.status = owbm_pkg::STATUS_BUSY;
        end
        else
        begin
            unique case (req.op)
                owbm_pkg::OP_RESET:
                begin
                    pullup_active_next = 1'b0;
                    run_kind_next      = req.op;
                    bit_counter_next   = 3'd0;
                    presence_seen_next = 1'b0;
                    phase_next         = PH_RST_LOW;
                    slot_timer_next    = owbm_pkg::T_RESET_LOW;
                end
                owbm_pkg::OP_WRITE:
                begin
                    pullup_active_next  = 1'b0;
                    run_kind_next       = req.op;
                    bit_counter_next    = 3'd0;
                    shift_byte_next     = req.data;
                    pullup_request_next = req.power;
                    phase_next          = PH_WR_LOW;
                    slot_timer_next     = req.data[0] ? owbm_pkg::T_SHORT_LOW
                                                      : owbm_pkg::T_WR0_LOW;
                end
                owbm_pkg::OP_READ:
                begin
                    pullup_active_next = 1'b0;
                    run_kind_next      = req.op;
                    bit_counter_next   = 3'd0;
                    shift_byte_next    = '0;
                    phase_next         = PH_RD_LOW;
                    slot_timer_next    = owbm_pkg::T_SHORT_LOW;
                end
                owbm_pkg::OP_TRIPLET:
                begin
                    pullup_active_next    = 1'b0;
                    run_kind_next         = req.op;
                    bit_counter_next      = 3'd0;
                    shift_byte_next       = {7'd0, req.search_direction};
                    first_read_next       = 1'b0;
                    second_read_next      = 1'b0;
                    chosen_direction_next = 1'b0;
                    phase_next            = PH_RD_LOW;
                    slot_timer_next       = owbm_pkg::T_SHORT_LOW;
                end
                default:
                begin
                    res_next.status   = owbm_pkg::STATUS_UNKNOWN;
                    res_next.done_res = 1'b1;
                end
            endcase
        end

        res_next.busy_res       = (phase_next != PH_IDLE)
                                  || (res_next.status == owbm_pkg::STATUS_BUSY);
        res_next.present        = presence_seen_next;
        res_next.read_value     = held_read_next;
        res_next.id_bit         = first_read_next;
        res_next.complement_bit = second_read_next;
        res_next.taken_bit      = chosen_direction_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            slot_timer_reg       <= '0;
            bit_counter_reg      <= '0;
            shift_byte_reg       <= '0;
            first_read_reg       <= 1'b0;
            second_read_reg      <= 1'b0;
            chosen_direction_reg <= 1'b0;
            pullup_request_reg   <= 1'b0;
            pullup_active_reg    <= 1'b0;
            presence_seen_reg    <= 1'b0;
            held_read_reg        <= '0;
            run_kind_reg         <= owbm_pkg::OP_NONE;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg            <= phase_next;
                slot_timer_reg       <= slot_timer_next;
                bit_counter_reg      <= bit_counter_next;
                shift_byte_reg       <= shift_byte_next;
                first_read_reg       <= first_read_next;
                second_read_reg      <= second_read_next;
                chosen_direction_reg <= chosen_direction_next;
                pullup_request_reg   <= pullup_request_next;
                pullup_active_reg    <= pullup_active_next;
                presence_seen_reg    <= presence_seen_next;
                held_read_reg        <= held_read_next;
                run_kind_reg         <= run_kind_next;
                res_valid_reg        <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.drive_low      = res_reg.drive_low;
    assign res.drive_high     = res_reg.drive_high;
    assign res.busy_res       = res_reg.busy_res;
    assign res.done_res       = res_reg.done_res;
    assign res.status         = res_reg.status;
    assign res.present        = res_reg.present;
    assign res.read_value     = res_reg.read_value;
    assign res.id_bit         = res_reg.id_bit;
    assign res.complement_bit = res_reg.complement_bit;
    assign res.taken_bit      = res_reg.taken_bit;

    `OWBM_ASSERT_IMPLIES(a_idle_timer_clear, clk, rst_n, phase_reg == PH_IDLE, slot_timer_reg == '0)
    `OWBM_ASSERT_IMPLIES(a_pullup_only_idle, clk, rst_n, pullup_active_reg, phase_reg == PH_IDLE)
    `OWBM_ASSERT_IMPLIES(a_kind_when_busy, clk, rst_n, phase_reg != PH_IDLE, run_kind_reg != owbm_pkg::OP_NONE)
    `OWBM_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, accept && res_next.done_res, phase_reg == PH_IDLE)
    `OWBM_ASSERT_IMPLIES(a_drive_exclusive, clk, rst_n, res_valid_reg, !(res_reg.drive_low && res_reg.drive_high))

endmodule
